@@ src/drf_pkg.sv @@
// Package: types and constants shared by the delayed-release ring FIFO modules.
package drf_pkg;

   localparam int CMD_W      = 2;
   localparam int PAYLOAD_W  = 64;
   localparam int SIZE_W     = 16;
   localparam int STAMP_W    = 32;
   localparam int STATUS_W   = 2;
   localparam int OCC_W      = 4;
   localparam int CAP_W      = 5;
   localparam int DELAY_W    = 16;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;

   localparam logic [CAP_W-1:0]   CAP_RESET   = 5'd16;
   localparam logic [DELAY_W-1:0] DELAY_RESET = 16'd0;

   localparam logic [CMD_W-1:0] CMD_TICK = 2'd0;
   localparam logic [CMD_W-1:0] CMD_PUT  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_POP  = 2'd2;

   localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

   localparam logic [CSR_IDX_W-1:0] REG_CAPACITY = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_DELAY    = 1'd1;

   typedef struct packed {
      logic [CMD_W-1:0]     command;
      logic [PAYLOAD_W-1:0] payload;
      logic [SIZE_W-1:0]    payload_size;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0]  status;
      logic                 head_ready;
      logic [PAYLOAD_W-1:0] head_payload;
      logic [SIZE_W-1:0]    head_size;
      logic [OCC_W-1:0]     occupancy;
   } rsp_type;

   // One ring slot.
   typedef struct packed {
      logic [PAYLOAD_W-1:0] payload;
      logic [SIZE_W-1:0]    size;
      logic [STAMP_W-1:0]   stamp;
   } entry_type;

endpackage

@@ src/delayed_release_ring_fifo_top.sv @@
// An accepted item waits in the input register until the ring step (pointer update, slot
//   write, head read, one 32-bit age compare) runs between input and result registers.
//   Throughput: one item per cycle while rsp_stall does not hold the result register.
// Reset (synchronous, active high): ring empty, tick counter zero, capacity 16, delay 0.
//   Slot contents are not cleared; only slots written by a put are ever reported.
module delayed_release_ring_fifo_top #(
   parameter int DEPTH     = 16,
   parameter int MAX_DELAY = 1000
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  drf_pkg::req_type                  req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output drf_pkg::rsp_type                  rsp_data,
   input  logic                              csr_write_enable,
   input  logic [drf_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [drf_pkg::CSR_DATA_W-1:0]    csr_write_data
);
   import drf_pkg::*;

   // Input stage: holds the accepted item until the ring step runs.
   logic    in_valid_ff, in_valid_in;
   req_type in_data_ff, in_data_in;

   // Result stage: holds the result until the consumer takes it.
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   logic    step_en;
   logic    req_accept;
   rsp_type step_result;

   // The step runs when the result register is free or being drained this cycle.
   assign step_en    = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall  = in_valid_ff && !step_en;
   assign req_accept = req_valid && !req_stall;

   drf_core #(.DEPTH(DEPTH), .MAX_DELAY(MAX_DELAY)) u_core (
      .clock            (clock),
      .reset            (reset),
      .step_en          (step_en),
      .item             (in_data_ff),
      .result           (step_result),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      in_data_in  = in_data_ff;
      if (step_en || !in_valid_ff) begin
         in_valid_in = req_valid;
      end
      if (req_accept) begin
         in_data_in = req_data;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (step_en) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = step_result;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers, no reset.
   always_ff @(posedge clock) begin
      in_data_ff  <= in_data_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

@@ src/drf_store.sv @@
// Slot storage: one write port, one combinational read port.
module drf_store #(
   parameter int DEPTH = 16,
   parameter int PW    = 4
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [PW-1:0]       wr_addr,
   input  drf_pkg::entry_type  wr_entry,
   input  logic [PW-1:0]       rd_addr,
   output drf_pkg::entry_type  rd_entry
);
   import drf_pkg::*;

   entry_type slot_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_ff[wr_addr] <= wr_entry;
      end
   end

   assign rd_entry = slot_ff[rd_addr];

endmodule

@@ src/drf_core.sv @@
// Ring control: config registers, positions, tick counter and head evaluation.
module drf_core #(
   parameter int DEPTH     = 16,
   parameter int MAX_DELAY = 1000
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              step_en,
   input  drf_pkg::req_type                  item,
   output drf_pkg::rsp_type                  result,
   input  logic                              csr_write_enable,
   input  logic [drf_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [drf_pkg::CSR_DATA_W-1:0]    csr_write_data
);
   import drf_pkg::*;

   localparam int PW = $clog2(DEPTH);
   localparam int CW = (PW + 1 > CAP_W) ? PW + 1 : CAP_W;

   logic [CAP_W-1:0]   capacity_ff, capacity_in;
   logic [DELAY_W-1:0] delay_ff, delay_in;
   logic [PW-1:0]      rd_pos_ff, rd_pos_in;
   logic [PW-1:0]      wr_pos_ff, wr_pos_in;
   logic [STAMP_W-1:0] now_ff, now_in;

   logic [CW-1:0]      cap_wide, cap_eff;
   logic [CW-1:0]      rd_next, wr_next;
   logic [PW-1:0]      rd_adv, wr_adv;
   logic [CW-1:0]      held;
   logic               ring_empty, ring_full, put_ok;
   logic [STATUS_W-1:0] status;
   logic [STAMP_W-1:0] need, age;
   entry_type          new_entry, rd_entry, head_entry;
   logic               head_valid, ready;

   drf_store #(.DEPTH(DEPTH), .PW(PW)) u_store (
      .clock    (clock),
      .wr_en    (put_ok),
      .wr_addr  (wr_pos_ff),
      .wr_entry (new_entry),
      .rd_addr  (rd_pos_in),
      .rd_entry (rd_entry)
   );

   // Capacity clamped into 2..DEPTH.
   always_comb begin
      cap_wide = CW'(capacity_ff);
      if (cap_wide < CW'(2)) begin
         cap_eff = CW'(2);
      end else if (cap_wide > CW'(DEPTH)) begin
         cap_eff = CW'(DEPTH);
      end else begin
         cap_eff = cap_wide;
      end
   end

   assign rd_next    = CW'(rd_pos_ff) + CW'(1);
   assign wr_next    = CW'(wr_pos_ff) + CW'(1);
   assign rd_adv     = (rd_next >= cap_eff) ? '0 : rd_next[PW-1:0];
   assign wr_adv     = (wr_next >= cap_eff) ? '0 : wr_next[PW-1:0];
   assign ring_empty = (rd_pos_ff == wr_pos_ff);
   assign ring_full  = (wr_adv == rd_pos_ff);

   assign new_entry.payload = item.payload;
   assign new_entry.size    = item.payload_size;
   assign new_entry.stamp   = now_ff;

   always_comb begin
      capacity_in = capacity_ff;
      delay_in    = delay_ff;
      rd_pos_in   = rd_pos_ff;
      wr_pos_in   = wr_pos_ff;
      now_in      = now_ff;
      status      = ST_DONE;
      put_ok      = 1'b0;
      if (step_en) begin
         case (item.command)
            CMD_TICK: begin
               now_in = now_ff + STAMP_W'(1);
            end
            CMD_PUT: begin
               if (ring_full) begin
                  status = ST_FULL;
               end else begin
                  put_ok    = 1'b1;
                  wr_pos_in = wr_adv;
               end
            end
            CMD_POP: begin
               if (ring_empty) begin
                  status = ST_EMPTY;
               end else begin
                  rd_pos_in = rd_adv;
               end
            end
            default: begin
            end
         endcase
      end
      if (csr_write_enable) begin
         unique case (csr_index)
            REG_CAPACITY: begin
               capacity_in = csr_write_data[CAP_W-1:0];
               rd_pos_in   = '0;
               wr_pos_in   = '0;
            end
            REG_DELAY: begin
               delay_in = csr_write_data[DELAY_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // Head after the step; a put into an empty ring is forwarded.
   assign head_entry = (put_ok && (rd_pos_in == wr_pos_ff)) ? new_entry : rd_entry;
   assign head_valid = (rd_pos_in != wr_pos_in);
   assign need       = (32'(delay_ff) > 32'(MAX_DELAY)) ? 32'(MAX_DELAY) : 32'(delay_ff);
   assign age        = now_in - head_entry.stamp;
   assign ready      = head_valid && (age >= need);

   assign held = (wr_pos_in >= rd_pos_in)
               ? CW'(wr_pos_in) - CW'(rd_pos_in)
               : CW'(wr_pos_in) + cap_eff - CW'(rd_pos_in);

   always_comb begin
      result.status       = status;
      result.head_ready   = ready;
      result.head_payload = ready ? head_entry.payload : '0;
      result.head_size    = ready ? head_entry.size : '0;
      result.occupancy    = held[OCC_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAP_RESET;
         delay_ff    <= DELAY_RESET;
         rd_pos_ff   <= '0;
         wr_pos_ff   <= '0;
         now_ff      <= '0;
      end else begin
         capacity_ff <= capacity_in;
         delay_ff    <= delay_in;
         rd_pos_ff   <= rd_pos_in;
         wr_pos_ff   <= wr_pos_in;
         now_ff      <= now_in;
      end
   end

endmodule

@@ sim/drf_checker.sv @@
// Checker: follows both channels and the register port, predicts each result item, compares.
`timescale 1ns / 100ps

module drf_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_stall,
   input  drf_pkg::req_type               req_data,
   input  logic                           rsp_valid,
   input  logic                           rsp_stall,
   input  drf_pkg::rsp_type               rsp_data,
   input  logic                           csr_write_enable,
   input  logic [drf_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [drf_pkg::CSR_DATA_W-1:0] csr_write_data,
   output int                             fail_count,
   output int                             pending_count,
   output int                             result_count,
   output int                             full_count,
   output int                             empty_count,
   output int                             ready_count
);
   import drf_pkg::*;

   localparam int RING_SLOTS = 16;
   localparam int AGE_CAP    = 1000;

   logic [PAYLOAD_W-1:0] ring_payload [RING_SLOTS];
   logic [SIZE_W-1:0]    ring_size    [RING_SLOTS];
   logic [STAMP_W-1:0]   ring_stamp   [RING_SLOTS];
   int unsigned          head_pos;
   int unsigned          tail_pos;
   logic [STAMP_W-1:0]   ms_count;
   logic [CAP_W-1:0]     capacity;
   logic [DELAY_W-1:0]   min_age;

   rsp_type head_reports_due [$];

   // out-of-range capacity is clamped to 2..RING_SLOTS
   function automatic int unsigned slots_in_use();
      if (capacity < 2) return 2;
      if (capacity > RING_SLOTS) return RING_SLOTS;
      return 32'(capacity);
   endfunction

   function automatic int unsigned step_pos(int unsigned pos);
      int unsigned nxt;
      nxt = pos + 1;
      return (nxt >= slots_in_use()) ? 0 : nxt;
   endfunction

   // Applies one command to the ring copy and returns the head report it causes.
   function automatic rsp_type next_head_report(req_type item);
      rsp_type            r;
      int unsigned        cap;
      int unsigned        nxt;
      int unsigned        need;
      int unsigned        held;
      logic [STAMP_W-1:0] age;
      r = '0;
      cap = slots_in_use();
      head_pos = head_pos % cap;
      tail_pos = tail_pos % cap;
      case (item.command)
         CMD_TICK: ms_count = ms_count + 1'b1;
         CMD_PUT: begin
            nxt = step_pos(tail_pos);
            if (nxt == head_pos) begin
               r.status = ST_FULL;
            end else begin
               ring_payload[tail_pos] = item.payload;
               ring_size[tail_pos]    = item.payload_size;
               ring_stamp[tail_pos]   = ms_count;
               tail_pos = nxt;
            end
         end
         CMD_POP: begin
            if (head_pos == tail_pos) r.status = ST_EMPTY;
            else head_pos = step_pos(head_pos);
         end
         default: ;
      endcase
      if (head_pos != tail_pos) begin
         // age wraps modulo 2^32 along with the counter
         age  = ms_count - ring_stamp[head_pos];
         need = (min_age > AGE_CAP) ? AGE_CAP : 32'(min_age);
         if (age >= need) begin
            r.head_ready   = 1'b1;
            r.head_payload = ring_payload[head_pos];
            r.head_size    = ring_size[head_pos];
         end
      end
      held = (tail_pos >= head_pos) ? tail_pos - head_pos : tail_pos + cap - head_pos;
      r.occupancy = OCC_W'(held);
      return r;
   endfunction

   always @(posedge clock) begin : watch
      rsp_type want;
      rsp_type got;
      int      bad;
      bad = 0;
      if (reset) begin
         head_pos = 0;
         tail_pos = 0;
         ms_count = '0;
         capacity = CAP_RESET;
         min_age  = DELAY_RESET;
         head_reports_due.delete();
         fail_count    <= 0;
         pending_count <= 0;
         result_count  <= 0;
         full_count    <= 0;
         empty_count   <= 0;
         ready_count   <= 0;
      end else begin
         if (csr_write_enable) begin
            if (csr_index == REG_CAPACITY) begin
               capacity = csr_write_data[CAP_W-1:0];
               head_pos = 0;
               tail_pos = 0;
            end else if (csr_index == REG_DELAY) begin
               min_age = csr_write_data[DELAY_W-1:0];
            end
         end
         if (rsp_valid && !rsp_stall) begin
            got = rsp_data;
            if (head_reports_due.size() == 0) begin
               $error("result item with nothing expected: %h", got);
               bad++;
            end else begin
               want = head_reports_due.pop_front();
               if (got.status !== want.status) begin
                  $error("status: expected %0d, actual %0d", want.status, got.status);
                  bad++;
               end
               if (got.head_ready !== want.head_ready) begin
                  $error("head_ready: expected %0d, actual %0d",
                         want.head_ready, got.head_ready);
                  bad++;
               end
               if (got.head_payload !== want.head_payload) begin
                  $error("head_payload: expected %h, actual %h",
                         want.head_payload, got.head_payload);
                  bad++;
               end
               if (got.head_size !== want.head_size) begin
                  $error("head_size: expected %h, actual %h", want.head_size, got.head_size);
                  bad++;
               end
               if (got.occupancy !== want.occupancy) begin
                  $error("occupancy: expected %0d, actual %0d",
                         want.occupancy, got.occupancy);
                  bad++;
               end
               full_count  <= full_count + int'(want.status == ST_FULL);
               empty_count <= empty_count + int'(want.status == ST_EMPTY);
               ready_count <= ready_count + int'(want.head_ready);
            end
            result_count <= result_count + 1;
         end
         if (req_valid && !req_stall) head_reports_due.push_back(next_head_report(req_data));
         pending_count <= head_reports_due.size();
         fail_count    <= fail_count + bad;
      end
   end

endmodule

@@ sim/tb_delayed_release_ring_fifo_top.sv @@
// Testbench top: drives commands and register writes into the ring FIFO and reports the verdict.
`timescale 1ns / 100ps

module tb_delayed_release_ring_fifo_top;
   import drf_pkg::*;

   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;   // code the block must ignore
   localparam int HOLD_CYCLES   = 60;                 // long receiver hold-off
   localparam int SETTLE_CYCLES = 4;                  // input and result registers, plus margin
   localparam int PHASES        = 12;
   localparam int PHASE_ITEMS   = 49;

   typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;

   // every DUT input starts at a known value
   logic                  clock            = 1'b0;
   logic                  reset            = 1'b1;
   logic                  req_valid        = 1'b0;
   req_type               req_data         = '0;
   logic                  rsp_stall        = 1'b0;
   logic                  csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index        = '0;
   logic [CSR_DATA_W-1:0] csr_write_data   = '0;

   logic    req_stall;
   logic    rsp_valid;
   rsp_type rsp_data;

   int fails, pending, results, full_refusals, empty_refusals, released;

   int send_idle_pct = 0;  // owned by the stimulus process
   int stall_pct     = 0;  // written with NBAs, read by the receiver
   int hold_serial   = 0;  // bumped by stimulus to request a hold-off
   int hold_seen     = 0;
   int hold_left     = 0;

   // capacity and delay per random phase; covers clamping below 2 and above 16,
   // plus the delay cap (65535 and 1000 both need 1000 ticks)
   int cap_table   [PHASES] = '{16, 2, 5, 31, 1, 8, 17, 3, 0, 12, 16, 9};
   int delay_table [PHASES] = '{0, 3, 1, 65535, 0, 10, 2, 7, 0, 25, 4, 1000};

   delayed_release_ring_fifo_top DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   drf_checker watch (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .fail_count       (fails),
      .pending_count    (pending),
      .result_count     (results),
      .full_count       (full_refusals),
      .empty_count      (empty_refusals),
      .ready_count      (released)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Receiver: random stall per cycle, or a counted hold-off when stimulus asks for one.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left <= 0;
         hold_seen <= 0;
      end else if (hold_serial != hold_seen) begin
         hold_seen <= hold_serial;
         hold_left <= HOLD_CYCLES - 1;
         rsp_stall <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   task automatic set_idle(idle_mode_type mode);
      case (mode)
         IDLE_NONE: begin
            send_idle_pct = 0;
            stall_pct <= 0;
         end
         IDLE_SENDER: begin
            send_idle_pct = 72;
            stall_pct <= 0;
         end
         IDLE_RECEIVER: begin
            send_idle_pct = 0;
            stall_pct <= 72;
         end
         default: begin
            send_idle_pct = 36;
            stall_pct <= 36;
         end
      endcase
   endtask

   function automatic req_type make_item(logic [CMD_W-1:0] cmd, logic [PAYLOAD_W-1:0] pay,
                                         logic [SIZE_W-1:0] sz);
      req_type item;
      item.command      = cmd;
      item.payload      = pay;
      item.payload_size = sz;
      return item;
   endfunction

   // Mostly well-formed traffic; unused fields carry noise, a few percent unused code.
   function automatic req_type random_item(int put_pct, int pop_pct);
      int               pick;
      logic [CMD_W-1:0] cmd;
      pick = $urandom_range(99);
      if (pick < put_pct) cmd = CMD_PUT;
      else if (pick < put_pct + pop_pct) cmd = CMD_POP;
      else if (pick < 97) cmd = CMD_TICK;
      else cmd = CMD_UNUSED;
      return make_item(cmd, {$urandom(), $urandom()}, SIZE_W'($urandom_range(65535)));
   endfunction

   // Offer one item and return at the edge that takes it. Valid stays high into the
   // next call unless that call opens a gap.
   task automatic send_item(req_type item);
      if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic send_cmd(logic [CMD_W-1:0] cmd);
      send_item(make_item(cmd, {$urandom(), $urandom()}, SIZE_W'($urandom_range(65535))));
   endtask

   // Stop offering, wait for every result item, then let the pipeline settle.
   task automatic go_idle();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic run_directed();
      set_idle(IDLE_NONE);
      // reset settings: capacity 16, delay 0
      send_cmd(CMD_POP);                                   // pop on empty ring
      send_cmd(CMD_UNUSED);                                // ignored code
      send_item(make_item(CMD_PUT, '1, '1));               // all-ones entry
      send_cmd(CMD_TICK);
      send_item(make_item(CMD_PUT, '0, '0));               // all-zeros entry
      send_cmd(CMD_POP);
      send_cmd(CMD_POP);
      send_cmd(CMD_POP);                                   // empty again
      go_idle();
      // capacity 0 acts as 2: room for one entry
      write_reg(REG_CAPACITY, 16'h0000);
      send_cmd(CMD_PUT);
      send_cmd(CMD_PUT);                                   // refused, full
      send_cmd(CMD_POP);
      go_idle();
      // capacity 3 with all upper data bits set; delay 3
      write_reg(REG_CAPACITY, 16'hFFE3);
      write_reg(REG_DELAY, 16'd3);
      send_cmd(CMD_PUT);
      send_cmd(CMD_PUT);
      send_cmd(CMD_PUT);                                   // refused, full
      repeat (3) send_cmd(CMD_TICK);                       // head ages into view
      send_cmd(CMD_POP);
   endtask

   // Hold entries past the 1000-tick cap; change the delay while they are held.
   task automatic run_aging();
      go_idle();
      set_idle(IDLE_BOTH);
      write_reg(REG_CAPACITY, 16'd4);
      write_reg(REG_DELAY, 16'hFFFF);
      send_cmd(CMD_PUT);
      send_cmd(CMD_PUT);
      repeat (500) send_cmd(CMD_TICK);
      go_idle();
      write_reg(REG_DELAY, 16'd400);                       // held head released at once
      send_cmd(CMD_TICK);
      go_idle();
      write_reg(REG_DELAY, 16'hFFFF);                      // back to the cap
      repeat (498) send_cmd(CMD_TICK);                     // age 999: still held back
      send_cmd(CMD_TICK);                                  // age 1000: released
      send_cmd(CMD_POP);
      send_cmd(CMD_TICK);
   endtask

   // Receiver holds off while the sender keeps offering, so the input backs up.
   task automatic run_pressure();
      go_idle();
      set_idle(IDLE_NONE);
      write_reg(REG_CAPACITY, 16'd16);
      write_reg(REG_DELAY, 16'd0);
      hold_serial <= hold_serial + 1;
      repeat (40) send_item(random_item(50, 20));
   endtask

   task automatic run_random();
      logic [CSR_DATA_W-1:0] cap_word;
      for (int ph = 0; ph < PHASES; ph++) begin
         go_idle();
         cap_word      = CSR_DATA_W'($urandom());
         cap_word[4:0] = 5'(cap_table[ph]);
         write_reg(REG_CAPACITY, cap_word);
         write_reg(REG_DELAY, CSR_DATA_W'(delay_table[ph]));
         set_idle(idle_mode_type'(ph % 4));
         // cycle through put shares of 25, 40 and 55 percent against 30 percent pops
         repeat (PHASE_ITEMS) send_item(random_item(25 + (ph % 3) * 15, 30));
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      run_directed();
      run_pressure();
      run_aging();
      run_random();
      go_idle();
      $display("Checked %0d result items: %0d refused puts, %0d refused pops, %0d heads released.",
               results, full_refusals, empty_refusals, released);
      $display("Ran %0d random phases, a long hold-off and an aging run past the tick cap.",
               PHASES);
      if (fails == 0 && pending == 0) begin
         $display("** delayed_release_ring_fifo_top: PASSED **");
      end else begin
         $display("** delayed_release_ring_fifo_top: FAILED **");
      end
      $finish;
   end

   // watchdog: far beyond the slowest correct run
   initial begin
      #2000000;
      $display("** delayed_release_ring_fifo_top: FAILED **");
      $finish;
   end

endmodule
